// ===== rtl/lscs_pkg.sv =====
// ----------------------------------------------------------------------------
// lscs_pkg
// Shared types and codes of the link session command supervisor.
// ----------------------------------------------------------------------------
package lscs_pkg;

	localparam int unsigned ACTION_COUNT   = 32;
	localparam int unsigned ENDPOINT_COUNT = 16;
	localparam int unsigned CFG_ADDR_W     = 5;

	// event kinds
	localparam logic [3:0] KIND_TICK      = 4'd0;
	localparam logic [3:0] KIND_HEARTBEAT = 4'd1;
	localparam logic [3:0] KIND_STATUS    = 4'd2;
	localparam logic [3:0] KIND_BAD_FRAME = 4'd3;
	localparam logic [3:0] KIND_START     = 4'd4;
	localparam logic [3:0] KIND_POLL      = 4'd5;
	localparam logic [3:0] KIND_CANCEL    = 4'd6;
	localparam logic [3:0] KIND_LINK_ERR  = 4'd7;
	localparam logic [3:0] KIND_TAKE      = 4'd8;

	// step status
	localparam logic [2:0] ST_NOT_STARTED = 3'd0;
	localparam logic [2:0] ST_RUNNING     = 3'd1;
	localparam logic [2:0] ST_DONE        = 3'd2;
	localparam logic [2:0] ST_FAILED      = 3'd3;
	localparam logic [2:0] ST_CANCELLED   = 3'd4;

	// failure codes
	localparam logic [3:0] FAIL_NONE        = 4'd0;
	localparam logic [3:0] FAIL_PEER_RESET  = 4'd1;
	localparam logic [3:0] FAIL_TIMEOUT     = 4'd2;
	localparam logic [3:0] FAIL_UNAVAILABLE = 4'd3;
	localparam logic [3:0] FAIL_PROTOCOL    = 4'd4;

	// emitted commands
	localparam logic [1:0] CMD_NONE   = 2'd0;
	localparam logic [1:0] CMD_START  = 2'd1;
	localparam logic [1:0] CMD_CANCEL = 2'd2;

	// register indexes
	localparam logic [2:0] REG_HEARTBEAT_INTERVAL = 3'd0;
	localparam logic [2:0] REG_LINK_TIMEOUT       = 3'd1;
	localparam logic [2:0] REG_RETRY_INTERVAL     = 3'd2;
	localparam logic [2:0] REG_PEER_ENDPOINT      = 3'd3;
	localparam logic [2:0] REG_ALLOWED_ACTIONS    = 3'd4;
	localparam logic [2:0] REG_OWN_SESSION        = 3'd5;

	typedef struct packed {
		logic [31:0] heartbeat_interval;
		logic [31:0] link_timeout;
		logic [31:0] retry_interval;
		logic [3:0]  peer_endpoint;
		logic [31:0] allowed_actions;
		logic [31:0] own_session;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] now_ms;
		logic [3:0]  sender;
		logic [31:0] exec_sess;
		logic [31:0] requester_session;
		logic [31:0] exec_tag;
		logic [31:0] cmd_tag;
		logic [2:0]  step_status;
		logic [3:0]  step_failure;
		logic [4:0]  action;
		logic        link_ready;
	} item_t;

	typedef struct packed {
		logic        heartbeat_sent;
		logic [1:0]  command_sent;
		logic [31:0] out_cmd_tag;
		logic [31:0] out_exec_tag;
		logic [4:0]  out_action;
		logic        ok;
		logic [2:0]  result_status;
		logic [3:0]  result_failure;
		logic [3:0]  taken_fault;
		logic [31:0] stale_count;
		logic [31:0] bad_frame_count;
		logic [31:0] resend_count;
	} result_t;

	typedef struct packed {
		logic [31:0] executor_session;
		logic [31:0] previous_session;
		logic [31:0] last_receive_time;
		logic [31:0] last_heartbeat_time;
		logic [31:0] last_send_time;
		logic        active;
		logic        cancel_wait;
		logic [2:0]  held_status;
		logic [3:0]  held_failure;
		logic [3:0]  peer_fault;
		logic [31:0] next_id;
		logic [31:0] current_id;
		logic [31:0] current_execution;
		logic [4:0]  current_action;
		logic [31:0] stale_events;
		logic [31:0] bad_frames;
		logic [31:0] resends;
	} state_t;

	// state after reset: everything clear, command ids start at one
	function automatic state_t state_reset();
		state_t s;
		s = '0;
		s.next_id = 32'd1;
		return s;
	endfunction

	function automatic logic waited(logic [31:0] now, logic [31:0] then_t, logic [31:0] span);
		logic [31:0] diff;
		diff = now - then_t;
		return diff >= span;
	endfunction

	function automatic logic is_terminal(logic [2:0] st);
		return st == ST_DONE || st == ST_FAILED || st == ST_CANCELLED;
	endfunction

endpackage

// ===== rtl/lscs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lscs_cfg_regs
// APB register file holding the supervisor configuration.
// ----------------------------------------------------------------------------
module lscs_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lscs_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output lscs_pkg::cfg_t                  cfg
);

	lscs_pkg::cfg_t cfg_q;
	logic [2:0]     reg_idx;
	logic           wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.heartbeat_interval <= 32'd100;
			cfg_q.link_timeout       <= 32'd500;
			cfg_q.retry_interval     <= 32'd200;
			cfg_q.peer_endpoint      <= 4'd1;
			cfg_q.allowed_actions    <= 32'd1;
			cfg_q.own_session        <= 32'd1;
		end else if (wr_en) begin
			unique case (reg_idx)
				lscs_pkg::REG_HEARTBEAT_INTERVAL: cfg_q.heartbeat_interval <= pwdata;
				lscs_pkg::REG_LINK_TIMEOUT:       cfg_q.link_timeout       <= pwdata;
				lscs_pkg::REG_RETRY_INTERVAL:     cfg_q.retry_interval     <= pwdata;
				lscs_pkg::REG_PEER_ENDPOINT:      cfg_q.peer_endpoint      <= pwdata[3:0];
				lscs_pkg::REG_ALLOWED_ACTIONS:    cfg_q.allowed_actions    <= pwdata;
				lscs_pkg::REG_OWN_SESSION:        cfg_q.own_session        <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			lscs_pkg::REG_HEARTBEAT_INTERVAL: prdata = cfg_q.heartbeat_interval;
			lscs_pkg::REG_LINK_TIMEOUT:       prdata = cfg_q.link_timeout;
			lscs_pkg::REG_RETRY_INTERVAL:     prdata = cfg_q.retry_interval;
			lscs_pkg::REG_PEER_ENDPOINT:      prdata = {28'd0, cfg_q.peer_endpoint};
			lscs_pkg::REG_ALLOWED_ACTIONS:    prdata = cfg_q.allowed_actions;
			lscs_pkg::REG_OWN_SESSION:        prdata = cfg_q.own_session;
			default:                          prdata = 32'd0;
		endcase
	end

endmodule

// ===== rtl/lscs_engine.sv =====
// ----------------------------------------------------------------------------
// lscs_engine
// Session, timer and command state with its single-pass next-state logic.
// ----------------------------------------------------------------------------
module lscs_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  lscs_pkg::item_t   item,
	input  lscs_pkg::cfg_t    cfg,
	output lscs_pkg::result_t res
);

	lscs_pkg::state_t state_q;
	lscs_pkg::state_t nxt;

	logic        hb, ok, polled;
	logic [1:0]  sent;
	logic [3:0]  pf_out;
	logic [2:0]  p_status;
	logic [3:0]  p_failure;
	logic        changed;
	logic        stop;

	always_comb begin
		nxt       = state_q;
		hb        = 1'b0;
		ok        = 1'b0;
		polled    = 1'b0;
		sent      = lscs_pkg::CMD_NONE;
		pf_out    = lscs_pkg::FAIL_NONE;
		p_status  = lscs_pkg::ST_NOT_STARTED;
		p_failure = lscs_pkg::FAIL_NONE;
		changed   = 1'b0;
		stop      = 1'b0;

		// session tracking shared by heartbeat and status frames
		if (item.kind == lscs_pkg::KIND_HEARTBEAT || item.kind == lscs_pkg::KIND_STATUS) begin
			changed = state_q.executor_session != '0 &&
				state_q.executor_session != item.exec_sess;
		end

		unique case (item.kind)
			lscs_pkg::KIND_TICK: begin
				if (state_q.last_heartbeat_time == '0 ||
					lscs_pkg::waited(item.now_ms, state_q.last_heartbeat_time,
					cfg.heartbeat_interval)) begin
					hb = item.link_ready;
					nxt.last_heartbeat_time = item.now_ms;
				end
				if (state_q.executor_session != '0 &&
					lscs_pkg::waited(item.now_ms, state_q.last_receive_time,
					cfg.link_timeout)) begin
					nxt.executor_session = '0;
					nxt.peer_fault = lscs_pkg::FAIL_TIMEOUT;
					if (state_q.active) begin
						nxt.held_status  = lscs_pkg::ST_FAILED;
						nxt.held_failure = lscs_pkg::FAIL_TIMEOUT;
					end
				end
				// retry looks at the status after a possible link loss
				if (nxt.active && (nxt.held_status == lscs_pkg::ST_RUNNING || nxt.cancel_wait) &&
					lscs_pkg::waited(item.now_ms, state_q.last_send_time,
					cfg.retry_interval)) begin
					if (item.link_ready) begin
						sent = nxt.cancel_wait ? lscs_pkg::CMD_CANCEL : lscs_pkg::CMD_START;
						nxt.resends = state_q.resends + 32'd1;
					end
					nxt.last_send_time = item.now_ms;
				end
			end
			lscs_pkg::KIND_HEARTBEAT, lscs_pkg::KIND_STATUS: begin
				if (item.kind == lscs_pkg::KIND_HEARTBEAT &&
					!(32'(item.sender) < 32'(lscs_pkg::ENDPOINT_COUNT) &&
					item.sender == cfg.peer_endpoint)) begin
					nxt.bad_frames = state_q.bad_frames + 32'd1;
				end else if (item.kind == lscs_pkg::KIND_STATUS &&
					item.requester_session != cfg.own_session) begin
					nxt.stale_events = state_q.stale_events + 32'd1;
				end else begin
					stop = changed;
					if (changed && item.exec_sess == state_q.previous_session) begin
						nxt.stale_events = state_q.stale_events + 32'd1;
					end else begin
						if (changed) begin
							nxt.previous_session = state_q.executor_session;
							nxt.peer_fault       = lscs_pkg::FAIL_PEER_RESET;
							nxt.cancel_wait      = 1'b0;
							if (state_q.active) begin
								nxt.held_status  = lscs_pkg::ST_FAILED;
								nxt.held_failure = lscs_pkg::FAIL_PEER_RESET;
							end
						end
						nxt.executor_session  = item.exec_sess;
						nxt.last_receive_time = item.now_ms;
					end
					if (item.kind == lscs_pkg::KIND_STATUS && !stop) begin
						if (!state_q.active || item.exec_tag != state_q.current_execution ||
							item.cmd_tag != state_q.current_id) begin
							nxt.stale_events = state_q.stale_events + 32'd1;
						end else begin
							nxt.held_status  = item.step_status;
							nxt.held_failure = item.step_failure;
							if (state_q.cancel_wait && lscs_pkg::is_terminal(item.step_status)) begin
								nxt.active      = 1'b0;
								nxt.cancel_wait = 1'b0;
							end
						end
					end
				end
			end
			lscs_pkg::KIND_BAD_FRAME: begin
				nxt.bad_frames = state_q.bad_frames + 32'd1;
			end
			lscs_pkg::KIND_START: begin
				if (!state_q.active && 32'(item.action) < 32'(lscs_pkg::ACTION_COUNT) &&
					cfg.allowed_actions[item.action]) begin
					nxt.active      = 1'b1;
					nxt.cancel_wait = 1'b0;
					if (state_q.executor_session == '0) begin
						nxt.held_status  = lscs_pkg::ST_FAILED;
						nxt.held_failure = lscs_pkg::FAIL_UNAVAILABLE;
						ok = 1'b1;
					end else begin
						nxt.current_id = state_q.next_id;
						nxt.next_id    = (state_q.next_id == '1) ? 32'd1 : state_q.next_id + 32'd1;
						nxt.current_execution = item.exec_tag;
						nxt.current_action    = item.action;
						nxt.held_status       = lscs_pkg::ST_RUNNING;
						nxt.held_failure      = lscs_pkg::FAIL_NONE;
						nxt.last_send_time    = item.now_ms;
						if (item.link_ready) begin
							sent = lscs_pkg::CMD_START;
							ok   = 1'b1;
						end else begin
							nxt.active = 1'b0;
						end
					end
				end
			end
			lscs_pkg::KIND_POLL: begin
				polled = 1'b1;
				if (!state_q.active) begin
					p_status  = lscs_pkg::ST_FAILED;
					p_failure = lscs_pkg::FAIL_PROTOCOL;
				end else begin
					p_status  = state_q.held_status;
					p_failure = state_q.held_failure;
					if (lscs_pkg::is_terminal(state_q.held_status) && !state_q.cancel_wait) begin
						nxt.active = 1'b0;
					end
				end
			end
			lscs_pkg::KIND_CANCEL: begin
				if (state_q.active) begin
					if (item.link_ready) begin
						sent = lscs_pkg::CMD_CANCEL;
					end
					nxt.last_send_time = item.now_ms;
					nxt.held_status    = lscs_pkg::ST_CANCELLED;
					nxt.held_failure   = lscs_pkg::FAIL_NONE;
					nxt.cancel_wait    = 1'b1;
				end
			end
			lscs_pkg::KIND_LINK_ERR: begin
				nxt.peer_fault = lscs_pkg::FAIL_TIMEOUT;
				if (state_q.active) begin
					nxt.held_status  = lscs_pkg::ST_FAILED;
					nxt.held_failure = lscs_pkg::FAIL_TIMEOUT;
				end
			end
			lscs_pkg::KIND_TAKE: begin
				if (state_q.peer_fault != lscs_pkg::FAIL_NONE) begin
					ok             = 1'b1;
					pf_out         = state_q.peer_fault;
					nxt.peer_fault = lscs_pkg::FAIL_NONE;
				end
			end
			default: ;
		endcase

		res.heartbeat_sent  = hb;
		res.command_sent    = sent;
		res.out_cmd_tag     = nxt.current_id;
		res.out_exec_tag    = nxt.current_execution;
		res.out_action      = nxt.current_action;
		res.ok              = ok;
		res.result_status   = polled ? p_status : nxt.held_status;
		res.result_failure  = polled ? p_failure : nxt.held_failure;
		res.taken_fault     = pf_out;
		res.stale_count     = nxt.stale_events;
		res.bad_frame_count = nxt.bad_frames;
		res.resend_count    = nxt.resends;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lscs_pkg::state_reset();
		end else if (advance) begin
			state_q <= nxt;
		end
	end

	a_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.next_id != '0)
		else $error("command id counter reached zero");

	a_cancel_needs_active: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.cancel_wait |-> state_q.active)
		else $error("cancel pending without an active command");

	a_silent_start: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item.kind == lscs_pkg::KIND_START && res.ok &&
		res.command_sent == lscs_pkg::CMD_NONE |-> state_q.executor_session == '0)
		else $error("accepted start sent nothing while an executor is known");

	a_take_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item.kind == lscs_pkg::KIND_TAKE |=> state_q.peer_fault == '0)
		else $error("peer fault survived a take");

endmodule

// ===== rtl/link_session_command_supervisor_core.sv =====
// ----------------------------------------------------------------------------
// link_session_command_supervisor_core
// Requester-side link supervisor: session tracking, heartbeat, timeout and
// command retry, with an APB configuration port.
// ----------------------------------------------------------------------------
// One result beat comes out for every item beat taken in, in order. The block
// takes one item per clock: an item is held in the input register, the
// single-pass update of the session and command state runs between that
// register and the result register, and the result is loaded into the result
// register when the held item advances. Throughput drops below one beat
// per clock only while the result beat is stalled; the input register
// still takes one more item during such a stall, so the upstream side
// sees stall only once both registers are full. Configuration registers
// sit at byte address 4*i in the order heartbeat_interval, link_timeout,
// retry_interval, peer endpoint, allowed_actions, own_session; write them
// only while no item is in flight. All time compares use wrapping
// millisecond differences, and all event counters wrap at 2^32.
// ----------------------------------------------------------------------------
module link_session_command_supervisor_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// item channel
	input  logic                            item_valid,
	output logic                            item_stall,
	input  lscs_pkg::item_t                 item,
	// result channel
	output logic                            result_valid,
	input  logic                            result_stall,
	output lscs_pkg::result_t               result,
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lscs_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	lscs_pkg::cfg_t    cfg;
	lscs_pkg::item_t   item_s1;
	logic              valid_s1;
	lscs_pkg::result_t res_comb;
	lscs_pkg::result_t result_q;
	logic              result_valid_q;
	logic              advance;
	logic              take_item;

	// advance the held item whenever the result register is free or draining
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign take_item  = item_valid && !item_stall;

	lscs_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lscs_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res_comb)
	);

	// input register: load a new beat, or drop the held one once it advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_item) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_item) begin
			item_s1 <= item;
		end
	end

	// result register: hold while stalled, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res_comb;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
